/* hdl/iasp_pkg.sv */
// Shared types, constants and helper functions of the interleaved access splitter.
// Used by every module in this folder; depends on nothing else.
`timescale 1ns / 1ps

package iasp_pkg;

  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 8;
  localparam int CLEN_W     = 13;
  localparam int BANK_W     = 6;
  localparam int PORT_W     = 7;
  localparam int GBITS_W    = 4;
  localparam int BSEL_W     = 3;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_PORTS  = 64;
  localparam int MAX_LENGTH = 252;
  localparam int GRAN_MIN   = 2;
  localparam int GRAN_MAX   = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRANULE_BITS = 3'd0,
    REG_BANK_SELECT  = 3'd1,
    REG_PORT_COUNT   = 3'd2,
    REG_BASE_OFFSET  = 3'd3,
    REG_SHIFT_AMOUNT = 3'd4,
    REG_COMPACT_MODE = 3'd5
  } cfg_reg_e;

  // Effective configuration, already saturated.
  typedef struct packed {
    logic [GBITS_W-1:0] gbits;
    logic [BSEL_W-1:0]  bsel;
    logic [PORT_W-1:0]  ports;
    logic [ADDR_W-1:0]  base;
    logic [SHIFT_W-1:0] shift;
    logic               compact;
  } cfg_t;

  // One chunk as it leaves the generator.
  typedef struct packed {
    logic [ADDR_W-1:0] cur;
    logic [CLEN_W-1:0] clen;
    logic [LEN_W-1:0]  pos;
    logic              wr;
    logic              glast;
    logic              zero;
  } chunk_t;

  // One chunk after address translation.
  typedef struct packed {
    logic [PORT_W-1:0] bank;
    logic [ADDR_W-1:0] naddr;
    logic [CLEN_W-1:0] clen;
    logic [LEN_W-1:0]  pos;
    logic              wr;
    logic              glast;
    logic              zero;
  } xlated_t;

  // Index of the highest set bit; zero and one both give zero.
  function automatic logic [BSEL_W-1:0] floor_log2(input logic [PORT_W-1:0] v);
    logic [BSEL_W-1:0] r;
    r = '0;
    for (int i = 0; i < PORT_W; i++) begin
      if (v[i]) begin
        r = BSEL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/iasp_cfg.sv */
// Configuration registers of the splitter and their saturated effective values.
// Depends on iasp_pkg.
`timescale 1ns / 1ps

module iasp_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [iasp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [iasp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output iasp_pkg::cfg_t                     cfg_o
);

  logic [iasp_pkg::GBITS_W-1:0] gbits_q;
  logic [iasp_pkg::BSEL_W-1:0]  bsel_q;
  logic [iasp_pkg::PORT_W-1:0]  ports_q;
  logic [iasp_pkg::ADDR_W-1:0]  base_q;
  logic [iasp_pkg::SHIFT_W-1:0] shift_q;
  logic                         compact_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gbits_q   <= iasp_pkg::GBITS_W'(iasp_pkg::GRAN_MIN);
      bsel_q    <= '0;
      ports_q   <= iasp_pkg::PORT_W'(1);
      base_q    <= '0;
      shift_q   <= '0;
      compact_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (iasp_pkg::cfg_reg_e'(cfg_index_i))
        iasp_pkg::REG_GRANULE_BITS: gbits_q   <= cfg_data_i[iasp_pkg::GBITS_W-1:0];
        iasp_pkg::REG_BANK_SELECT:  bsel_q    <= cfg_data_i[iasp_pkg::BSEL_W-1:0];
        iasp_pkg::REG_PORT_COUNT:   ports_q   <= cfg_data_i[iasp_pkg::PORT_W-1:0];
        iasp_pkg::REG_BASE_OFFSET:  base_q    <= cfg_data_i[iasp_pkg::ADDR_W-1:0];
        iasp_pkg::REG_SHIFT_AMOUNT: shift_q   <= cfg_data_i[iasp_pkg::SHIFT_W-1:0];
        iasp_pkg::REG_COMPACT_MODE: compact_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [iasp_pkg::PORT_W-1:0] ports_sat;

  always_comb begin
    ports_sat = (ports_q > iasp_pkg::PORT_W'(iasp_pkg::MAX_PORTS))
              ? iasp_pkg::PORT_W'(iasp_pkg::MAX_PORTS) : ports_q;
    cfg_o.ports = ports_sat;
    if (gbits_q < iasp_pkg::GBITS_W'(iasp_pkg::GRAN_MIN)) begin
      cfg_o.gbits = iasp_pkg::GBITS_W'(iasp_pkg::GRAN_MIN);
    end else if (gbits_q > iasp_pkg::GBITS_W'(iasp_pkg::GRAN_MAX)) begin
      cfg_o.gbits = iasp_pkg::GBITS_W'(iasp_pkg::GRAN_MAX);
    end else begin
      cfg_o.gbits = gbits_q;
    end
    cfg_o.bsel    = (bsel_q == '0) ? iasp_pkg::floor_log2(ports_sat) : bsel_q;
    cfg_o.base    = base_q;
    cfg_o.shift   = shift_q;
    cfg_o.compact = compact_q;
  end

endmodule

/* hdl/iasp_gen.sv */
// Input register and chunk generator: cuts one access into granule-sized chunks,
// one chunk per cycle unless the translation stage stalls it. Depends on iasp_pkg.
`timescale 1ns / 1ps

module iasp_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iasp_pkg::cfg_t                 cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [iasp_pkg::ADDR_W-1:0]    address_i,
  input  logic [iasp_pkg::LEN_W-1:0]     length_i,
  input  logic                           wr_access_i,
  output logic                           chunk_valid_o,
  output iasp_pkg::chunk_t               chunk_o,
  input  logic                           chunk_stall_i
);

  // Input stage.
  logic                          s1_v_q;
  logic [iasp_pkg::ADDR_W-1:0]   s1_cur_q, s1_cur_d;
  logic [iasp_pkg::LEN_W-1:0]    s1_len_q, s1_len_d;
  logic [iasp_pkg::CLEN_W-1:0]   s1_first_q, s1_first_d;
  logic                          s1_wr_q;
  logic                          s1_zero_q, s1_zero_d;

  // Generator working registers.
  logic                          w_v_q;
  logic [iasp_pkg::ADDR_W-1:0]   w_cur_q;
  logic [iasp_pkg::LEN_W-1:0]    w_len_q;
  logic [iasp_pkg::LEN_W-1:0]    w_pos_q;
  logic [iasp_pkg::CLEN_W-1:0]   w_first_q;
  logic                          w_wr_q;
  logic                          w_zero_q;

  logic [iasp_pkg::CLEN_W-1:0]   gran;
  logic [iasp_pkg::CLEN_W-1:0]   gmask;
  logic [iasp_pkg::CLEN_W-1:0]   low;
  logic [iasp_pkg::LEN_W-1:0]    rem;
  logic [iasp_pkg::CLEN_W-1:0]   craw;
  logic [iasp_pkg::CLEN_W-1:0]   clen;
  logic                          glast;
  logic                          emit, load, s1_take;

  always_comb begin
    gran  = iasp_pkg::CLEN_W'(1) << cfg_i.gbits;
    gmask = gran - iasp_pkg::CLEN_W'(1);

    s1_len_d  = (length_i > iasp_pkg::LEN_W'(iasp_pkg::MAX_LENGTH))
              ? iasp_pkg::LEN_W'(iasp_pkg::MAX_LENGTH) : length_i;
    s1_zero_d = (s1_len_d == '0);
    low       = iasp_pkg::CLEN_W'(address_i) & gmask;
    s1_first_d = (low == '0) ? '0 : gran - low;
    // A zero-length access reports its raw address, so the offset is not removed.
    s1_cur_d  = s1_zero_d ? address_i : address_i - cfg_i.base;

    rem   = w_len_q - w_pos_q;
    craw  = (w_first_q != '0) ? w_first_q : gran;
    if (w_zero_q) begin
      clen = '0;
    end else if (craw > iasp_pkg::CLEN_W'(rem)) begin
      clen = iasp_pkg::CLEN_W'(rem);
    end else begin
      clen = craw;
    end
    glast = w_zero_q || (clen == iasp_pkg::CLEN_W'(rem));

    emit    = w_v_q && !chunk_stall_i;
    load    = s1_v_q && (!w_v_q || (emit && glast));
    s1_take = in_valid_i && (!s1_v_q || load);
  end

  assign in_stall_o    = s1_v_q && !load;
  assign chunk_valid_o = w_v_q;

  always_comb begin
    chunk_o.cur   = w_cur_q;
    chunk_o.clen  = clen;
    chunk_o.pos   = w_pos_q;
    chunk_o.wr    = w_wr_q;
    chunk_o.glast = glast;
    chunk_o.zero  = w_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      w_v_q  <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_v_q <= 1'b1;
      end else if (load) begin
        s1_v_q <= 1'b0;
      end
      if (load) begin
        w_v_q <= 1'b1;
      end else if (emit && glast) begin
        w_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_cur_q   <= s1_cur_d;
      s1_len_q   <= s1_len_d;
      s1_first_q <= s1_first_d;
      s1_wr_q    <= wr_access_i;
      s1_zero_q  <= s1_zero_d;
    end
    if (load) begin
      w_cur_q   <= s1_cur_q;
      w_len_q   <= s1_len_q;
      w_pos_q   <= '0;
      w_first_q <= s1_first_q;
      w_wr_q    <= s1_wr_q;
      w_zero_q  <= s1_zero_q;
    end else if (emit) begin
      w_cur_q   <= w_cur_q + iasp_pkg::ADDR_W'(clen);
      w_pos_q   <= w_pos_q + clen[iasp_pkg::LEN_W-1:0];
      w_first_q <= '0;
    end
  end

endmodule

/* hdl/iasp_xlate.sv */
// Address translation: removes nothing more, picks the bank and rewrites the chunk
// address in compact, shifted or unchanged mode. Two register stages. Depends on iasp_pkg.
`timescale 1ns / 1ps

module iasp_xlate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iasp_pkg::cfg_t      cfg_i,
  input  logic                chunk_valid_i,
  input  iasp_pkg::chunk_t    chunk_i,
  output logic                chunk_stall_o,
  output logic                xl_valid_o,
  output iasp_pkg::xlated_t   xl_o,
  input  logic                xl_stall_i
);

  logic                s2_v_q;
  iasp_pkg::chunk_t    s2_q;
  logic                s3_v_q;
  iasp_pkg::xlated_t   s3_q, s3_d;
  logic                s2_ready, s3_ready;

  logic [iasp_pkg::ADDR_W-1:0]  gmask, hmask, cur;
  logic [iasp_pkg::PORT_W:0]    bmask_w;
  logic [iasp_pkg::PORT_W-1:0]  bmask;
  logic [iasp_pkg::GBITS_W:0]   gb_sum;
  logic [iasp_pkg::SHIFT_W:0]   gs_sum;
  logic [iasp_pkg::ADDR_W-1:0]  by_g, by_gs;

  assign s3_ready      = !s3_v_q || !xl_stall_i;
  assign s2_ready      = !s2_v_q || s3_ready;
  assign chunk_stall_o = !s2_ready;
  assign xl_valid_o    = s3_v_q;
  assign xl_o          = s3_q;

  always_comb begin
    cur     = s2_q.cur;
    gmask   = (iasp_pkg::ADDR_W'(1) << cfg_i.gbits) - iasp_pkg::ADDR_W'(1);
    bmask_w = ((iasp_pkg::PORT_W + 1)'(1) << cfg_i.bsel) - (iasp_pkg::PORT_W + 1)'(1);
    bmask   = bmask_w[iasp_pkg::PORT_W-1:0];
    gb_sum  = (iasp_pkg::GBITS_W + 1)'(cfg_i.gbits) + (iasp_pkg::GBITS_W + 1)'(cfg_i.bsel);
    hmask   = ~((iasp_pkg::ADDR_W'(1) << gb_sum) - iasp_pkg::ADDR_W'(1));
    gs_sum  = (iasp_pkg::SHIFT_W + 1)'(cfg_i.gbits) + (iasp_pkg::SHIFT_W + 1)'(cfg_i.shift);
    by_g    = cur >> cfg_i.gbits;
    by_gs   = cur >> gs_sum;

    s3_d.clen  = s2_q.clen;
    s3_d.pos   = s2_q.pos;
    s3_d.wr    = s2_q.wr;
    s3_d.glast = s2_q.glast;
    s3_d.zero  = s2_q.zero;

    if (s2_q.zero) begin
      s3_d.bank  = '0;
      s3_d.naddr = cur;
    end else if (cfg_i.compact) begin
      s3_d.bank  = by_g[iasp_pkg::PORT_W-1:0] & bmask;
      s3_d.naddr = ((cur & hmask) >> cfg_i.bsel) + (cur & gmask);
    end else if (cfg_i.shift != '0) begin
      s3_d.bank  = by_gs[iasp_pkg::PORT_W-1:0] & bmask;
      s3_d.naddr = ((cur >> cfg_i.shift) & ~gmask) | (cur & gmask);
    end else begin
      s3_d.bank  = by_g[iasp_pkg::PORT_W-1:0] & bmask;
      s3_d.naddr = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_q <= chunk_valid_i;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && chunk_valid_i) begin
      s2_q <= chunk_i;
    end
    if (s3_ready && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

endmodule

/* hdl/iasp_out.sv */
// Bank check and output register: flags a bank at or beyond the port count, ends the
// access there and discards the rest of its chunks. Depends on iasp_pkg.
`timescale 1ns / 1ps

module iasp_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  iasp_pkg::cfg_t                  cfg_i,
  input  logic                            xl_valid_i,
  input  iasp_pkg::xlated_t               xl_i,
  output logic                            xl_stall_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [iasp_pkg::BANK_W-1:0]     bank_o,
  output logic [iasp_pkg::ADDR_W-1:0]     chunk_address_o,
  output logic [iasp_pkg::CLEN_W-1:0]     chunk_length_o,
  output logic [iasp_pkg::LEN_W-1:0]      data_position_o,
  output logic                            write_flag_o,
  output logic                            status_o,
  output logic                            last_o
);

  logic out_v_q;
  logic drop_q;
  logic ready, take, invalid;

  assign ready       = !out_v_q || !out_stall_i;
  assign take        = xl_valid_i && ready;
  assign invalid     = !xl_i.zero && (xl_i.bank >= cfg_i.ports);
  assign xl_stall_o  = !ready;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      if (ready) begin
        out_v_q <= take && !drop_q;
      end
      // Once an access has failed, its remaining chunks are swallowed up to its last one.
      if (take) begin
        if (drop_q) begin
          drop_q <= !xl_i.glast;
        end else begin
          drop_q <= invalid && !xl_i.glast;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !drop_q) begin
      bank_o          <= xl_i.bank[iasp_pkg::BANK_W-1:0];
      chunk_address_o <= xl_i.naddr;
      chunk_length_o  <= xl_i.clen;
      data_position_o <= xl_i.pos;
      write_flag_o    <= xl_i.wr;
      status_o        <= invalid;
      last_o          <= xl_i.glast || invalid;
    end
  end

endmodule

/* hdl/interleaved_access_splitter.sv */
// Interleaved access splitter, top level: configuration registers, chunk generator,
// address translation and output stage. Depends on iasp_pkg and the iasp_* modules.
`timescale 1ns / 1ps

// An access word is split into chunks that each stay inside one interleave granule;
// every chunk leaves as one output word with its bank, translated address, length and
// byte position. The chunk generator produces one chunk per cycle unless the translation
// stage stalls it, and an access is accepted whenever the input register is empty or
// hands its access on to the generator. The first output word of an access passes the
// input register, the generator register, both translation stages and the output stage.
// When a chunk hits a bank at or beyond the port count it goes out with status set and
// last set; the remaining chunks of that access still pass the generator, one a cycle
// unless stalled, and are discarded at the output stage. Configuration is written
// through a plain write port and must only be changed while no access is in flight.
module interleaved_access_splitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [iasp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [iasp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [iasp_pkg::ADDR_W-1:0]     address_i,
  input  logic [iasp_pkg::LEN_W-1:0]      length_i,
  input  logic                            wr_access_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [iasp_pkg::BANK_W-1:0]     bank_o,
  output logic [iasp_pkg::ADDR_W-1:0]     chunk_address_o,
  output logic [iasp_pkg::CLEN_W-1:0]     chunk_length_o,
  output logic [iasp_pkg::LEN_W-1:0]      data_position_o,
  output logic                            write_flag_o,
  output logic                            status_o,
  output logic                            last_o
);

  iasp_pkg::cfg_t     cfg;
  logic               chunk_valid, chunk_stall;
  iasp_pkg::chunk_t   chunk;
  logic               xl_valid, xl_stall;
  iasp_pkg::xlated_t  xl;

  iasp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  iasp_gen u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .address_i     (address_i),
    .length_i      (length_i),
    .wr_access_i   (wr_access_i),
    .chunk_valid_o (chunk_valid),
    .chunk_o       (chunk),
    .chunk_stall_i (chunk_stall)
  );

  iasp_xlate u_xlate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .chunk_valid_i (chunk_valid),
    .chunk_i       (chunk),
    .chunk_stall_o (chunk_stall),
    .xl_valid_o    (xl_valid),
    .xl_o          (xl),
    .xl_stall_i    (xl_stall)
  );

  iasp_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .xl_valid_i      (xl_valid),
    .xl_i            (xl),
    .xl_stall_o      (xl_stall),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bank_o          (bank_o),
    .chunk_address_o (chunk_address_o),
    .chunk_length_o  (chunk_length_o),
    .data_position_o (data_position_o),
    .write_flag_o    (write_flag_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

endmodule

/* test/tb_interleaved_access_splitter.sv */
// Self-checking testbench for interleaved_access_splitter: splits random and directed
// accesses under many register settings and compares every output word with a local
// prediction. Depends on iasp_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module tb_interleaved_access_splitter;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 20;

  typedef struct packed {
    logic [iasp_pkg::ADDR_W-1:0] address;
    logic [iasp_pkg::LEN_W-1:0]  length;
    logic                        wr_access;
  } access_t;

  typedef struct packed {
    logic [iasp_pkg::BANK_W-1:0] bank;
    logic [iasp_pkg::ADDR_W-1:0] addr;
    logic [iasp_pkg::CLEN_W-1:0] clen;
    logic [iasp_pkg::LEN_W-1:0]  pos;
    logic                        wr;
    logic                        status;
    logic                        last;
  } chunk_word_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we_i    = 1'b0;
  logic [iasp_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [iasp_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [iasp_pkg::ADDR_W-1:0]     address_i   = '0;
  logic [iasp_pkg::LEN_W-1:0]      length_i    = '0;
  logic                            wr_access_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [iasp_pkg::BANK_W-1:0]     bank_o;
  logic [iasp_pkg::ADDR_W-1:0]     chunk_address_o;
  logic [iasp_pkg::CLEN_W-1:0]     chunk_length_o;
  logic [iasp_pkg::LEN_W-1:0]      data_position_o;
  logic                            write_flag_o;
  logic                            status_o;
  logic                            last_o;

  // Local copy of the register file, as written.
  logic [iasp_pkg::GBITS_W-1:0] m_gbits   = 4'd2;
  logic [iasp_pkg::BSEL_W-1:0]  m_bsel    = '0;
  logic [iasp_pkg::PORT_W-1:0]  m_ports   = 7'd1;
  logic [iasp_pkg::ADDR_W-1:0]  m_base    = '0;
  logic [iasp_pkg::SHIFT_W-1:0] m_shift   = '0;
  logic                         m_compact = 1'b0;

  access_t     access_q[$];
  chunk_word_t chunk_exp_q[$];
  access_t     cur_access;
  chunk_word_t exp_word;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned error_count     = 0;
  logic        hold_off        = 1'b0;
  bit          pressure_go     = 1'b0;

  interleaved_access_splitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .address_i       (address_i),
    .length_i        (length_i),
    .wr_access_i     (wr_access_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .bank_o          (bank_o),
    .chunk_address_o (chunk_address_o),
    .chunk_length_o  (chunk_length_o),
    .data_position_o (data_position_o),
    .write_flag_o    (write_flag_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input logic [63:0] expv,
                                 input logic [63:0] gotv);
    if (error_count < 100) begin
      $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, expv, gotv);
    end
    error_count++;
  endtask

  // Splits one access under the current registers and queues the expected words.
  function automatic void split_access(input access_t a);
    int unsigned g, b, s, ports, len, pos, chunk, first, gran;
    logic [63:0] cur, naddr, bank, gmask, bmask, hmask;
    chunk_word_t w;
    bit          aborted;
    g = m_gbits;
    if (g < iasp_pkg::GRAN_MIN) g = iasp_pkg::GRAN_MIN;
    if (g > iasp_pkg::GRAN_MAX) g = iasp_pkg::GRAN_MAX;
    len = a.length;
    if (len > iasp_pkg::MAX_LENGTH) len = iasp_pkg::MAX_LENGTH;
    ports = m_ports;
    if (ports > iasp_pkg::MAX_PORTS) ports = iasp_pkg::MAX_PORTS;
    b = m_bsel;
    if (b == 0) begin
      while ((1 << (b + 1)) <= ports) b++;
    end
    s = m_shift;
    gran  = 1 << g;
    gmask = 64'(gran - 1);
    bmask = (64'd1 << b) - 64'd1;
    hmask = ~((64'd1 << (g + b)) - 64'd1);
    w.wr = a.wr_access;
    if (len == 0) begin
      w.bank = '0; w.addr = a.address; w.clen = '0; w.pos = '0;
      w.status = 1'b0; w.last = 1'b1;
      chunk_exp_q.push_back(w);
      return;
    end
    // The first chunk ends at the boundary of the original, not the rebased, address.
    first = int'(a.address & gmask[iasp_pkg::ADDR_W-1:0]);
    if (first != 0) first = gran - first;
    cur = {32'd0, a.address - m_base};
    pos = 0;
    aborted = 1'b0;
    while (pos < len && !aborted) begin
      chunk = gran;
      if (first != 0) begin
        chunk = first;
        first = 0;
      end
      if (chunk > len - pos) chunk = len - pos;
      bank = (cur >> g) & bmask;
      if (m_compact) begin
        naddr = ((cur & hmask) >> b) + (cur & gmask);
      end else if (s != 0) begin
        bank  = (cur >> (g + s)) & bmask;
        naddr = ((cur >> s) & (~64'd0 << g)) | (cur & gmask);
      end else begin
        naddr = cur;
      end
      w.bank = bank[iasp_pkg::BANK_W-1:0];
      w.addr = naddr[iasp_pkg::ADDR_W-1:0];
      w.clen = iasp_pkg::CLEN_W'(chunk);
      w.pos  = iasp_pkg::LEN_W'(pos);
      if (bank >= 64'(ports)) begin
        w.status = 1'b1;
        w.last   = 1'b1;
        aborted  = 1'b1;
      end else begin
        w.status = 1'b0;
        w.last   = (pos + chunk >= len);
      end
      chunk_exp_q.push_back(w);
      pos += chunk;
      cur = (cur + 64'(chunk)) & 64'hFFFF_FFFF;
    end
  endfunction

  // Driver: presents queued accesses, holding each word until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        split_access(cur_access);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (access_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_access = access_q.pop_front();
          address_i   <= cur_access.address;
          length_i    <= cur_access.length;
          wr_access_i <= cur_access.wr_access;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted output word and drives the receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (chunk_exp_q.size() == 0) begin
          report_mismatch("unexpected word", 64'd0, {32'd0, chunk_address_o});
        end else begin
          exp_word = chunk_exp_q.pop_front();
          if (bank_o !== exp_word.bank) report_mismatch("bank", exp_word.bank, bank_o);
          if (chunk_address_o !== exp_word.addr)
            report_mismatch("chunk_address", exp_word.addr, chunk_address_o);
          if (chunk_length_o !== exp_word.clen)
            report_mismatch("chunk_length", exp_word.clen, chunk_length_o);
          if (data_position_o !== exp_word.pos)
            report_mismatch("data_position", exp_word.pos, data_position_o);
          if (write_flag_o !== exp_word.wr)
            report_mismatch("write_flag", exp_word.wr, write_flag_o);
          if (status_o !== exp_word.status)
            report_mismatch("status", exp_word.status, status_o);
          if (last_o !== exp_word.last) report_mismatch("last", exp_word.last, last_o);
        end
      end
      out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off so that the splitter backs up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL interleaved_access_splitter");
    $finish;
  end

  task automatic write_config(input logic [31:0] gb, bs, pc, bo, sa, cm);
    logic [31:0]        v;
    iasp_pkg::cfg_reg_e r;
    for (int i = 0; i <= int'(iasp_pkg::REG_COMPACT_MODE); i++) begin
      r = iasp_pkg::cfg_reg_e'(i);
      case (r)
        iasp_pkg::REG_GRANULE_BITS: begin v = gb; m_gbits   = v[iasp_pkg::GBITS_W-1:0]; end
        iasp_pkg::REG_BANK_SELECT:  begin v = bs; m_bsel    = v[iasp_pkg::BSEL_W-1:0];  end
        iasp_pkg::REG_PORT_COUNT:   begin v = pc; m_ports   = v[iasp_pkg::PORT_W-1:0];  end
        iasp_pkg::REG_BASE_OFFSET:  begin v = bo; m_base    = v[iasp_pkg::ADDR_W-1:0];  end
        iasp_pkg::REG_SHIFT_AMOUNT: begin v = sa; m_shift   = v[iasp_pkg::SHIFT_W-1:0]; end
        iasp_pkg::REG_COMPACT_MODE: begin v = cm; m_compact = v[0];                     end
        default:                    v = '0;
      endcase
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= r;
      cfg_data_i  <= v;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Unused upper bits of the narrow registers carry random junk.
  task automatic write_random_config();
    logic [31:0] gb, bs, pc, bo, sa;
    gb = ($urandom_range(99) < 80)
       ? $urandom_range(iasp_pkg::GRAN_MAX, iasp_pkg::GRAN_MIN) : $urandom_range(15);
    bs = ($urandom_range(99) < 60) ? 0 : $urandom_range(7, 1);
    case ($urandom_range(9))
      0:       pc = 0;
      1:       pc = $urandom_range(127, 65);
      default: pc = $urandom_range(iasp_pkg::MAX_PORTS, 1);
    endcase
    case ($urandom_range(3))
      0, 1:    bo = 0;
      2:       bo = $urandom;
      default: bo = $urandom_range(4095);
    endcase
    case ($urandom_range(9))
      0, 1, 2: sa = $urandom_range(16, 1);
      3:       sa = $urandom_range(31, 17);
      default: sa = 0;
    endcase
    write_config(($urandom << iasp_pkg::GBITS_W) | gb, ($urandom << iasp_pkg::BSEL_W) | bs,
                 ($urandom << iasp_pkg::PORT_W) | pc, bo,
                 ($urandom << iasp_pkg::SHIFT_W) | sa,
                 ($urandom << 1) | $urandom_range(1));
  endtask

  function automatic access_t random_access();
    access_t a;
    case ($urandom_range(9))
      6, 7:    a.address = ($urandom & 32'hFFFF_F000) | $urandom_range(15)
                         | (($urandom_range(1) == 1) ? 32'h0000_0FF0 : 32'h0);
      8:       a.address = 32'hFFFF_FF00 | $urandom_range(255);
      9:       a.address = $urandom_range(1023);
      default: a.address = $urandom;
    endcase
    case ($urandom_range(19))
      0:       a.length = '0;
      1, 2:    a.length = $urandom_range(255, 200);
      default: a.length = $urandom_range(64, 1);
    endcase
    a.wr_access = $urandom_range(1);
    return a;
  endfunction

  task automatic push_access(input logic [31:0] addr, input int unsigned len,
                             input logic wr);
    access_t a;
    a.address   = addr;
    a.length    = iasp_pkg::LEN_W'(len);
    a.wr_access = wr;
    access_q.push_back(a);
  endtask

  // Waits until every queued access has gone and every expected word has arrived,
  // then lets discarded chunks of an aborted access leave the generator. The check
  // runs just after the edge so that the driver's updates of that edge are seen.
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (access_q.size() != 0 || in_valid_i || chunk_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned sidle, input int unsigned ridle,
                           input bit pressure);
    sender_idle_pct = sidle;
    recv_stall_pct  = ridle;
    pressure_go     = pressure;
    repeat (PHASE_ITEMS) access_q.push_back(random_access());
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct = 20;
    recv_stall_pct  = 49;

    // Reset settings: zero lengths, address wrap, oversized length, misaligned starts.
    push_access(32'h0000_0000, 0, 1'b0);
    push_access(32'hFFFF_FFFF, 0, 1'b1);
    push_access(32'hFFFF_FFFE, 255, 1'b1);
    push_access(32'h0000_0001, 5, 1'b0);
    push_access(32'h0000_0004, 4, 1'b1);
    drain();

    // Compact mode, with an address below the base offset.
    write_config(4, 0, 4, 32'h100, 0, 1);
    push_access(32'h0000_0100, 64, 1'b0);
    push_access(32'h0000_010F, 33, 1'b1);
    push_access(32'h0000_0050, 17, 1'b0);
    drain();

    // Shifted mode with three ports: bank three is invalid.
    write_config(3, 2, 3, 0, 4, 0);
    push_access(32'h0000_0180, 16, 1'b0);
    push_access(32'h0000_007F, 40, 1'b1);
    push_access(32'h0000_0000, 200, 1'b0);
    drain();

    // Out-of-range granule, oversized port count, bank select of seven, large shift.
    write_config(15, 7, 127, 32'hFFFF_FFFF, 31, 0);
    push_access(32'h0000_0000, 252, 1'b1);
    push_access(32'h0000_0FFF, 100, 1'b0);
    push_access(32'hFFFF_F000, 253, 1'b1);
    drain();

    // Zero ports: every chunk of nonzero length is invalid.
    write_config(0, 0, 0, 0, 0, 0);
    push_access(32'h0000_0010, 8, 1'b1);
    push_access(32'h8000_0003, 1, 1'b0);
    push_access(32'h0000_0020, 0, 1'b0);
    drain();

    // Compact mode with seven bank bits: banks beyond 63 are flagged.
    write_config(2, 7, 64, 0, 0, 1);
    push_access(32'h0000_01FC, 12, 1'b0);
    push_access(32'h0000_00F0, 24, 1'b1);
    push_access(32'h0000_0000, 252, 1'b0);
    drain();

    // Extremes of the legal register ranges.
    write_config(iasp_pkg::GRAN_MAX, 6, iasp_pkg::MAX_PORTS, 32'hFFFF_FFFF, 16, 1);
    run_phase(20, 49, 1'b0);
    write_config(iasp_pkg::GRAN_MIN, 0, iasp_pkg::MAX_PORTS, $urandom_range(4095), 16, 0);
    run_phase(20, 49, 1'b0);
    write_random_config();
    run_phase(20, 49, 1'b0);
    for (int p = 0; p < 3; p++) begin
      write_random_config();
      run_phase(49, 20, 1'b0);
    end
    write_config(iasp_pkg::GRAN_MIN, 0, 16, 0, 0, 0);
    run_phase(0, 0, 1'b1);
    write_random_config();
    run_phase(0, 0, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS interleaved_access_splitter");
    end else begin
      $display("FAIL interleaved_access_splitter");
    end
    $finish;
  end

endmodule
